@@ rtl/flptw_pkg.sv @@
// Package with the shared constants and types of the four-level page-table walker.
package flptw_pkg;

    localparam int STORE_PAGES = 64;
    localparam int STORE_WORDS = STORE_PAGES * 512;
    localparam int STORE_AW    = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

    // Wide enough for any walk address and any store depth in range.
    localparam int CMP_W = 23;

    localparam int ROOT_W  = 18;
    localparam int LIMIT_W = 19;
    localparam int PA_W    = 52;
    localparam int VA_W    = 48;
    localparam int ENTRY_W = 64;
    localparam int WADDR_W = 15;
    localparam int IDX_W   = 9;

    localparam int S_TDATA_W = 128;
    localparam int M_TDATA_W = 56;

    typedef enum logic {
        KIND_WRITE     = 1'b0,
        KIND_TRANSLATE = 1'b1
    } item_kind_t;

    typedef enum logic {
        CFG_ROOT_TABLE   = 1'b0,
        CFG_MEMORY_LIMIT = 1'b1
    } cfg_index_t;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(262144);

endpackage

@@ rtl/four_level_page_table_walker_core.sv @@
// Four-level page-table walker over a page-table store held in one synchronous memory.
//
// After reset the block first clears its table store, one word per cycle, over
// STORE_PAGES * 512 words (32768 with the default size); s_axis_tready stays low
// during that pass while configuration writes are taken as usual. A write word
// is stored as it is accepted and then passes ST_FINISH. A translate word has its
// root checked and the first table read issued as it is accepted; ST_CHECK then
// takes each level's read from the store's single read port (up to four), and
// ST_FINISH loads the result once the output register is free; a failing check
// ends the walk early. A new input word is accepted as soon as the previous result
// has been moved to the output register, even while that result waits to be taken.
module four_level_page_table_walker_core
    import flptw_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [LIMIT_W-1:0]   cfg_data,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // Fields from bit 0: word_addr[14:0], entry_value[78:15], virt_addr[126:79], zero pad.
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // Fields from bit 0: kind.
    input  logic                 s_axis_tuser,

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // Fields from bit 0: xlat_addr[51:0], zero pad.
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // Fields from bit 0: mapped.
    output logic                 m_axis_tuser
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_FINISH
    } state_t;

    localparam logic [STORE_AW-1:0] LAST_WORD   = STORE_AW'(STORE_WORDS - 1);
    localparam logic [CMP_W-1:0]    STORE_DEPTH = CMP_W'(STORE_WORDS);

    logic [ENTRY_W-1:0] mem [STORE_WORDS];

    state_t             state_reg;
    logic [STORE_AW-1:0] clr_cnt_reg;
    logic [1:0]         level_reg;
    logic               oob_reg;
    logic [VA_W-1:0]    va_reg;
    logic [PA_W-1:0]    res_phys_reg;
    logic               res_mapped_reg;
    logic [ENTRY_W-1:0] rd_data_reg;

    logic [ROOT_W-1:0]  root_table_reg;
    logic [LIMIT_W-1:0] memory_limit_reg;

    logic               m_valid_reg;
    logic [PA_W-1:0]    m_phys_reg;
    logic               m_mapped_reg;

    logic               in_accept;
    logic [WADDR_W-1:0] in_waddr;
    logic [ENTRY_W-1:0] in_value;
    logic [VA_W-1:0]    in_va;

    logic [ENTRY_W-1:0] entry;
    logic [PA_W-1:0]    frame;
    logic               root_ok;
    logic               frame_ok;
    logic [LIMIT_W-1:0] walk_base;
    logic [VA_W-1:0]    walk_va;
    logic [1:0]         walk_lvl;
    logic [CMP_W-1:0]   rd_addr_wide;
    logic               rd_oob;
    logic [CMP_W-1:0]   wr_addr_wide;

    logic               mem_we;
    logic [STORE_AW-1:0] mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [STORE_AW-1:0] mem_raddr;
    logic               out_free;

    function automatic logic ptr_ok(input logic [PA_W-1:0] addr,
                                    input logic [LIMIT_W-1:0] limit);
        logic nonzero;
        logic aligned;
        logic below;
        nonzero = (addr != '0);
        aligned = (addr[11:0] == 12'd0);
        below   = (addr < PA_W'(limit));
        return nonzero && aligned && below;
    endfunction

    function automatic logic [IDX_W-1:0] lvl_index(input logic [VA_W-1:0] va,
                                                   input logic [1:0] lvl);
        logic [IDX_W-1:0] idx;
        case (lvl)
            2'd0:    idx = va[47:39];
            2'd1:    idx = va[38:30];
            2'd2:    idx = va[29:21];
            default: idx = va[20:12];
        endcase
        return idx;
    endfunction

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_waddr      = s_axis_tdata[14:0];
    assign in_value      = s_axis_tdata[78:15];
    assign in_va         = s_axis_tdata[126:79];

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {(M_TDATA_W - PA_W)'(0), m_phys_reg};
    assign m_axis_tuser  = m_mapped_reg;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign entry    = oob_reg ? '0 : rd_data_reg;
    assign frame    = {entry[51:12], 12'd0};
    assign root_ok  = ptr_ok(PA_W'(root_table_reg), memory_limit_reg);
    assign frame_ok = ptr_ok(frame, memory_limit_reg);

    always_comb begin
        if (state_reg == ST_IDLE) begin
            walk_base = LIMIT_W'(root_table_reg);
            walk_va   = in_va;
            walk_lvl  = 2'd0;
        end else begin
            walk_base = frame[LIMIT_W-1:0];
            walk_va   = va_reg;
            walk_lvl  = level_reg + 2'd1;
        end
        rd_addr_wide = CMP_W'(walk_base[LIMIT_W-1:3]) + CMP_W'(lvl_index(walk_va, walk_lvl));
        rd_oob       = (rd_addr_wide >= STORE_DEPTH);
        wr_addr_wide = CMP_W'(in_waddr);
    end

    always_comb begin
        mem_raddr = rd_addr_wide[STORE_AW-1:0];
        if (state_reg == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = in_accept && (s_axis_tuser == KIND_WRITE)
                        && (wr_addr_wide < STORE_DEPTH);
            mem_waddr = wr_addr_wide[STORE_AW-1:0];
            mem_wdata = in_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_table_reg   <= '0;
            memory_limit_reg <= LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_ROOT_TABLE:   root_table_reg   <= cfg_data[ROOT_W-1:0];
                CFG_MEMORY_LIMIT: memory_limit_reg <= cfg_data;
                default:          root_table_reg   <= root_table_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            level_reg   <= '0;
            oob_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_axis_tready && (state_reg != ST_FINISH)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + STORE_AW'(1);
                    if (clr_cnt_reg == LAST_WORD) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_accept) begin
                        va_reg         <= in_va;
                        res_phys_reg   <= '0;
                        res_mapped_reg <= 1'b0;
                        level_reg      <= 2'd0;
                        oob_reg        <= rd_oob;
                        if (s_axis_tuser == KIND_TRANSLATE && root_ok) begin
                            state_reg <= ST_CHECK;
                        end else begin
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_CHECK: begin
                    if (!entry[0]) begin
                        state_reg <= ST_FINISH;
                    end else if (level_reg == 2'd3) begin
                        res_phys_reg   <= {entry[51:12], va_reg[11:0]};
                        res_mapped_reg <= 1'b1;
                        state_reg      <= ST_FINISH;
                    end else if (!frame_ok) begin
                        state_reg <= ST_FINISH;
                    end else begin
                        level_reg <= level_reg + 2'd1;
                        oob_reg   <= rd_oob;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_phys_reg   <= res_phys_reg;
                        m_mapped_reg <= res_mapped_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_axis_tready)
        else $error("input accepted during the clearing pass");

    a_unmapped_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("unmapped result carries a nonzero address");

    a_one_item_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second word accepted before the first one finished");

    a_result_after_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && out_free) |=> (m_axis_tvalid && state_reg == ST_IDLE))
        else $error("finished result was not loaded into the output register");

endmodule

@@ tb/sv/four_level_page_table_walker_core_tb.sv @@
// Self-checking testbench for the four-level page-table walker core.
`timescale 1ns / 100ps

module four_level_page_table_walker_core_tb;
    import flptw_pkg::*;

    localparam int RANDOM_ITEMS = 1000;
    localparam int PHASES       = 8;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int TAIL_CYCLES  = 20;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;
    localparam logic [VA_W-1:0]    VA_ONES   = '1;

    typedef struct {
        item_kind_t          kind;
        logic [WADDR_W-1:0]  word_addr;
        logic [ENTRY_W-1:0]  entry_value;
        logic [VA_W-1:0]     virt_addr;
    } walk_word_t;

    typedef struct packed {
        logic [PA_W-1:0] xlat_addr;
        logic            mapped;
    } walk_result_t;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_TRANSLATE,
        ROW_REG
    } row_op_t;

    typedef enum logic {
        CHK_MODEL,
        CHK_FIXED
    } row_check_t;

    // The addr field holds the word index, the virtual address or the register index.
    typedef struct packed {
        row_op_t             op;
        logic [VA_W-1:0]     addr;
        logic [ENTRY_W-1:0]  data;
        row_check_t          check;
        walk_result_t        fixed;
    } dir_row_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_PERIODIC,
        RX_SPARSE
    } rx_mode_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    cfg_index_t           cfg_index     = CFG_ROOT_TABLE;
    logic [LIMIT_W-1:0]   cfg_data      = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 s_axis_tuser  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;

    logic [ENTRY_W-1:0] table_mirror [STORE_WORDS];
    logic [ROOT_W-1:0]  root_reg  = '0;
    logic [LIMIT_W-1:0] limit_reg = LIMIT_RESET;
    walk_result_t       pending_results [$];
    dir_row_t           dir_table [$];

    int       err_count      = 0;
    int       writes_sent    = 0;
    int       translates_sent = 0;
    int       results_seen   = 0;
    int       mapped_seen    = 0;
    int       reg_writes     = 0;
    int       burst_left     = 0;
    int       cycle_count    = 0;
    int       rx_hold        = 0;
    rx_mode_t rx_mode        = RX_OPEN;

    four_level_page_table_walker_core u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic bit table_ptr_ok(logic [PA_W-1:0] ptr);
        return ptr != '0 && ptr < PA_W'(limit_reg) && ptr[11:0] == 12'b0;
    endfunction

    function automatic logic [ENTRY_W-1:0] read_mirror(logic [PA_W-1:0] tbl,
                                                       logic [IDX_W-1:0] idx);
        logic [63:0] w;
        w = (64'(tbl) >> 3) + 64'(idx);
        if (w >= 64'(STORE_WORDS)) return '0;
        return table_mirror[w[STORE_AW-1:0]];
    endfunction

    function automatic walk_result_t predict_walk(logic [VA_W-1:0] va);
        logic [PA_W-1:0]    tbl;
        logic [ENTRY_W-1:0] entry;
        walk_result_t       res;
        int                 lvl;
        res = '0;
        tbl = PA_W'(root_reg);
        if (!table_ptr_ok(tbl)) return res;
        for (lvl = 0; lvl < 4; lvl++) begin
            entry = read_mirror(tbl, va[47 - 9 * lvl -: IDX_W]);
            if (!entry[0]) return res;
            if (lvl < 3) begin
                tbl = {entry[51:12], 12'b0};
                if (!table_ptr_ok(tbl)) return res;
            end
        end
        res.xlat_addr = {entry[51:12], va[11:0]};
        res.mapped    = 1'b1;
        return res;
    endfunction

    function automatic walk_word_t random_word();
        walk_word_t w;
        w.kind        = item_kind_t'($urandom_range(0, 1));
        w.word_addr   = WADDR_W'($urandom);
        w.entry_value = {$urandom, $urandom};
        w.virt_addr   = VA_W'({$urandom, $urandom});
        return w;
    endfunction

    function automatic logic [PA_W-1:0] pick_table_ptr();
        case ($urandom_range(0, 15))
            0: begin
                return '0;
            end
            1: begin
                return PA_W'($urandom_range(STORE_PAGES, 2 * STORE_PAGES - 1)) << 12;
            end
            2: begin
                return {40'({$urandom, $urandom}), 12'b0};
            end
            default: begin
                return PA_W'($urandom_range(1, STORE_PAGES - 1)) << 12;
            end
        endcase
    endfunction

    function automatic dir_row_t row_wr(logic [WADDR_W-1:0] a, logic [ENTRY_W-1:0] d);
        return '{ROW_WRITE, VA_W'(a), d, CHK_FIXED, '0};
    endfunction

    function automatic dir_row_t row_tr(logic [VA_W-1:0] va);
        return '{ROW_TRANSLATE, va, '0, CHK_MODEL, '0};
    endfunction

    function automatic dir_row_t row_tr_fixed(logic [VA_W-1:0] va, logic [PA_W-1:0] pa,
                                              logic mapped);
        return '{ROW_TRANSLATE, va, '0, CHK_FIXED, '{pa, mapped}};
    endfunction

    function automatic dir_row_t row_reg(cfg_index_t idx, logic [LIMIT_W-1:0] v);
        return '{ROW_REG, VA_W'(idx), ENTRY_W'(v), CHK_MODEL, '0};
    endfunction

    task automatic send_word(input walk_word_t w, input bit use_fixed,
                             input walk_result_t fixed);
        int           gap;
        walk_result_t res;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'({w.virt_addr, w.entry_value, w.word_addr});
        s_axis_tuser  <= w.kind;
        do @(posedge aclk); while (!s_axis_tready);
        burst_left--;
        res = '0;
        if (w.kind == KIND_WRITE) begin
            if (int'(w.word_addr) < STORE_WORDS) table_mirror[w.word_addr] = w.entry_value;
            writes_sent++;
        end else begin
            res = predict_walk(w.virt_addr);
            translates_sent++;
        end
        pending_results.push_back(use_fixed ? fixed : res);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [LIMIT_W-1:0] v);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_ROOT_TABLE) root_reg = v[ROOT_W-1:0];
        else limit_reg = v;
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    always @(posedge aclk) begin : result_check
        walk_result_t exp_res;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word xlat_addr=%h mapped=%b",
                         $time, m_axis_tdata, m_axis_tuser);
                err_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (m_axis_tdata !== M_TDATA_W'(exp_res.xlat_addr)) begin
                    $display("%0t: xlat_addr mismatch expected=%h actual=%h",
                             $time, M_TDATA_W'(exp_res.xlat_addr), m_axis_tdata);
                    err_count++;
                end
                if (m_axis_tuser !== exp_res.mapped) begin
                    $display("%0t: mapped mismatch expected=%b actual=%b",
                             $time, exp_res.mapped, m_axis_tuser);
                    err_count++;
                end
                if (m_axis_tuser === 1'b1) mapped_seen++;
                results_seen++;
            end
        end
    end

    always @(posedge aclk) begin : ready_pattern
        if (rx_hold == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_hold <= $urandom_range(20, 300);
        end else begin
            rx_hold <= rx_hold - 1;
        end
        case (rx_mode)
            RX_OPEN: begin
                m_axis_tready <= 1'b1;
            end
            RX_RANDOM: begin
                m_axis_tready <= 1'($urandom_range(0, 1));
            end
            RX_PERIODIC: begin
                m_axis_tready <= (cycle_count % 4 == 0);
            end
            default: begin
                m_axis_tready <= ($urandom_range(0, 31) == 0);
            end
        endcase
    end

    always @(posedge aclk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d result words outstanding",
                     $time, pending_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        dir_row_t           row;
        walk_word_t         w;
        walk_result_t       no_fixed;
        logic [VA_W-1:0]    va;
        logic [VA_W-1:0]    recent_va [$];
        logic [PA_W-1:0]    tbl;
        logic [PA_W-1:0]    nxt;
        logic [LIMIT_W-1:0] root_val;
        logic [LIMIT_W-1:0] limit_val;
        int                 ph;
        int                 lvl;
        int                 k;
        int                 target;

        no_fixed = '0;
        for (int i = 0; i < STORE_WORDS; i++) table_mirror[i] = '0;

        // Tables at pages 1 to 4, reached by the all-ones virtual address.
        dir_table.push_back(row_tr_fixed('0, '0, 1'b0));
        dir_table.push_back(row_wr('0, '1));
        dir_table.push_back(row_wr('1, '1));
        dir_table.push_back(row_reg(CFG_ROOT_TABLE, 19'h01000));
        dir_table.push_back(row_wr(15'd1023, 64'h2001));
        dir_table.push_back(row_wr(15'd1535, 64'h3001));
        dir_table.push_back(row_wr(15'd2047, 64'h4001));
        dir_table.push_back(row_wr(15'd2559, '1));
        dir_table.push_back(row_tr_fixed(VA_ONES, '1, 1'b1));
        dir_table.push_back(row_reg(CFG_MEMORY_LIMIT, 19'h04000));
        dir_table.push_back(row_tr_fixed(VA_ONES, '0, 1'b0));
        dir_table.push_back(row_reg(CFG_MEMORY_LIMIT, 19'h04001));
        dir_table.push_back(row_tr(VA_ONES));
        dir_table.push_back(row_reg(CFG_MEMORY_LIMIT, '0));
        dir_table.push_back(row_tr_fixed(VA_ONES, '0, 1'b0));
        dir_table.push_back(row_reg(CFG_MEMORY_LIMIT, LIMIT_MAX));
        dir_table.push_back(row_wr(15'd2047, 64'h40001));
        dir_table.push_back(row_tr(VA_ONES));
        dir_table.push_back(row_wr(15'd2047, 64'hFFF0_0000_0000_4FFF));
        dir_table.push_back(row_wr(15'd2559, 64'h1));
        dir_table.push_back(row_tr(48'hFFFF_FFFF_F123));
        dir_table.push_back(row_wr(15'd1535, 64'h1));
        dir_table.push_back(row_tr_fixed(VA_ONES, '0, 1'b0));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_table[i]) begin
            row = dir_table[i];
            w   = random_word();
            case (row.op)
                ROW_REG: begin
                    write_reg(cfg_index_t'(row.addr[0]), row.data[LIMIT_W-1:0]);
                end
                ROW_WRITE: begin
                    w.kind        = KIND_WRITE;
                    w.word_addr   = row.addr[WADDR_W-1:0];
                    w.entry_value = row.data;
                    send_word(w, row.check == CHK_FIXED, row.fixed);
                end
                default: begin
                    w.kind      = KIND_TRANSLATE;
                    w.virt_addr = row.addr;
                    send_word(w, row.check == CHK_FIXED, row.fixed);
                end
            endcase
        end

        for (ph = 0; ph < PHASES; ph++) begin
            root_val  = {1'($urandom_range(0, 1)), 6'($urandom_range(1, STORE_PAGES - 1)),
                         12'b0};
            limit_val = LIMIT_RESET;
            case (ph)
                1, 7: begin
                    limit_val = LIMIT_MAX;
                end
                2: begin
                    limit_val = LIMIT_W'($urandom_range(4096, 262144));
                end
                3: begin
                    root_val  = '0;
                    limit_val = LIMIT_W'($urandom);
                end
                4: begin
                    root_val  = LIMIT_W'($urandom);
                    limit_val = LIMIT_W'($urandom);
                end
                6: begin
                    root_val  = LIMIT_W'(262143);
                    limit_val = '0;
                end
                default: begin
                end
            endcase
            write_reg(CFG_ROOT_TABLE, root_val);
            write_reg(CFG_MEMORY_LIMIT, limit_val);

            target = dir_table.size() + (ph + 1) * RANDOM_ITEMS / PHASES;
            while (writes_sent + translates_sent < target) begin
                k = $urandom_range(0, 9);
                w = random_word();
                if (k <= 6) begin
                    va  = VA_W'({$urandom, $urandom});
                    tbl = PA_W'({root_reg[ROOT_W-1:12], 12'b0});
                    for (lvl = 0; lvl < 4; lvl++) begin
                        nxt = (lvl < 3) ? pick_table_ptr() : {40'({$urandom, $urandom}), 12'b0};
                        w = random_word();
                        w.kind        = KIND_WRITE;
                        w.word_addr   = WADDR_W'(64'(tbl) >> 3) +
                                        WADDR_W'(va[47 - 9 * lvl -: IDX_W]);
                        w.entry_value = {w.entry_value[63:52], nxt[51:12], w.entry_value[11:1],
                                         1'($urandom_range(0, 15) != 0)};
                        send_word(w, 1'b0, no_fixed);
                        tbl = nxt;
                    end
                    for (lvl = 0; lvl < 2; lvl++) begin
                        w = random_word();
                        w.kind      = KIND_TRANSLATE;
                        w.virt_addr = (lvl == 0) ? va : {va[47:12], 12'($urandom)};
                        send_word(w, 1'b0, no_fixed);
                    end
                    recent_va.push_back(va);
                    if (recent_va.size() > 16) void'(recent_va.pop_front());
                end else if (k == 9 && recent_va.size() != 0) begin
                    w.kind      = KIND_TRANSLATE;
                    va          = recent_va[$urandom_range(0, recent_va.size() - 1)];
                    w.virt_addr = {va[47:12], 12'($urandom)};
                    send_word(w, 1'b0, no_fixed);
                end else begin
                    w.kind = (k == 7) ? KIND_WRITE : KIND_TRANSLATE;
                    send_word(w, 1'b0, no_fixed);
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Checked %0d result words for %0d table writes and %0d walks, %0d mapped.",
                 results_seen, writes_sent, translates_sent, mapped_seen);
        $display("Used %0d register writes over %0d settings of root and limit, extremes included.",
                 reg_writes, PHASES);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches, %0d result words missing", err_count,
                     pending_results.size());
            $display("FAILURE");
        end
        $finish;
    end

endmodule
